// File: src/two_queue_interleave_checker_macros.svh
// Assertion helpers for the interleave checker.
`ifndef TWO_QUEUE_INTERLEAVE_CHECKER_MACROS_SVH
`define TWO_QUEUE_INTERLEAVE_CHECKER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TQIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TQIC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tqic_pkg.sv
package tqic_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    ACT_PUSH_A = 2'd0,
    ACT_PUSH_B = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_CMP  = 1'b1
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qsts_t;

endpackage

// File: src/two_queue_interleave_checker.sv
// Channel  Handshake                 Payload
// in       in_valid / in_ready       in_action, in_value
// out      out_valid / out_ready     out_verdict, out_overflow
//
// Push and finish items act in their accept cycle; a check item also
// passes through S_CMP: the queue heads come out of registered memory
// reads, then the compare and pop happen. Input is held off in S_CMP and
// while a verdict waits in the output register. Synchronous reset clears
// pointers, counts and flags; memory contents are left as they are.
`include "two_queue_interleave_checker_macros.svh"

module two_queue_interleave_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_verdict,
  output logic                 out_overflow
);
  import tqic_pkg::*;

  state_t state_r, state_nxt;

  qctl_t ctl_a, ctl_b;
  qsts_t sts_a, sts_b;
  data_t head_a, head_b;

  data_t value_r;
  logic  mismatch_r, mismatch_nxt;
  logic  overflow_r, overflow_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  verdict_r, verdict_nxt;
  logic  out_ovf_r, out_ovf_nxt;

  logic    accept;
  action_t act;
  logic    hit_a, hit_b;

  assign act    = action_t'(in_action);
  assign accept = in_valid && in_ready;
  assign hit_a  = !sts_a.empty && (head_a == value_r);
  assign hit_b  = !sts_b.empty && (head_b == value_r);

  tqic_queue u_queue_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_a),
    .wdata     ($unsigned(in_value)),
    .sts       (sts_a),
    .head_data (head_a)
  );

  tqic_queue u_queue_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_b),
    .wdata     ($unsigned(in_value)),
    .sts       (sts_b),
    .head_data (head_b)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && act == ACT_CHECK) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    in_ready      = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    ctl_a         = '0;
    ctl_b         = '0;
    mismatch_nxt  = mismatch_r;
    overflow_nxt  = overflow_r;
    out_valid_nxt = out_valid_r && !out_ready;
    verdict_nxt   = verdict_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (act)
            ACT_PUSH_A: begin
              ctl_a.push = 1'b1;
              if (sts_a.full) overflow_nxt = 1'b1;
            end
            ACT_PUSH_B: begin
              ctl_b.push = 1'b1;
              if (sts_b.full) overflow_nxt = 1'b1;
            end
            ACT_FINISH: begin
              out_valid_nxt = 1'b1;
              verdict_nxt   = !mismatch_r && sts_a.empty && sts_b.empty;
              out_ovf_nxt   = overflow_r;
              ctl_a.clear   = 1'b1;
              ctl_b.clear   = 1'b1;
              mismatch_nxt  = 1'b0;
              overflow_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_CMP: begin
        // A wins when both heads match.
        if (hit_a) begin
          ctl_a.pop = 1'b1;
        end else if (hit_b) begin
          ctl_b.pop = 1'b1;
        end else begin
          mismatch_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= $unsigned(in_value);
    end
    verdict_r <= verdict_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mismatch_r  <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mismatch_r  <= mismatch_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_verdict  = verdict_r;
  assign out_overflow = out_ovf_r;

  `TQIC_ASSERT_ALWAYS(a_single_pop, !(ctl_a.pop && ctl_b.pop), "both queues popped at once")
  `TQIC_ASSERT(a_cmp_blocks_input, (state_r == S_CMP) |-> !in_ready, "input taken during compare")
  `TQIC_ASSERT(a_check_to_cmp, (accept && act == ACT_CHECK) |=> (state_r == S_CMP), "check without compare")
  `TQIC_ASSERT(a_finish_result, (accept && act == ACT_FINISH) |=> out_valid_r, "finish gave no result")

endmodule

// File: src/tqic_queue.sv
module tqic_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  tqic_pkg::qctl_t  ctl,
  input  tqic_pkg::data_t  wdata,
  output tqic_pkg::qsts_t  sts,
  output tqic_pkg::data_t  head_data
);
  import tqic_pkg::*;

  data_t mem [QUEUE_DEPTH];
  data_t head_data_r;

  addr_t head_r, head_nxt;
  addr_t tail_r, tail_nxt;
  cnt_t  count_r, count_nxt;

  logic do_push;
  logic do_pop;

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_push   = ctl.push && !sts.full;
  assign do_pop    = ctl.pop && !sts.empty;
  assign head_data = head_data_r;

  // The head entry is read every cycle into a register, head_data_r.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= wdata;
    end
    head_data_r <= mem[head_r];
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (do_push) begin
        tail_nxt = (tail_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      end
      if (do_pop) begin
        head_nxt = (head_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_nxt = count_r + 1'b1;
        2'b01:   count_nxt = count_r - 1'b1;
        default: count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
